// File: rtl/srle_pkg.sv
// ----------------------------------------------------------------------------
// Sprite RLE decoder package
// Shared constants, payload types, state encodings and the RGB555 expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package srle_pkg;

  localparam int ADDRESS_BITS  = 26;
  localparam int WIDTH_BITS    = 12;
  localparam int ATLAS_BITS    = 14;
  localparam int LENGTH_BITS   = 24;
  localparam int BYTE_BITS     = 8;
  localparam int ROWS_BITS     = BYTE_BITS + 1;
  localparam int STEP_BITS     = $clog2(BYTE_BITS);
  localparam int COLOR_BITS    = 32;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int ALU_BITS      =
    ((ADDRESS_BITS > WIDTH_BITS + 1) ? ADDRESS_BITS : WIDTH_BITS + 1) + 1;

  localparam logic [BYTE_BITS-1:0] SKIP_CONTROL = 8'd255;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_ROW_PITCH     = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS  = 2'd2;
  localparam logic [1:0] REG_STREAM_LENGTH = 2'd3;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_SKIP,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    SK_IDLE,
    SK_DIV,
    SK_FIX_ADD,
    SK_FIX_SUB,
    SK_MUL
  } skip_state_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 start_image;
  } in_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] pixel_address;
    logic [COLOR_BITS-1:0]   pixel_color;
  } out_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0]    skip;
    logic [WIDTH_BITS-1:0]   column;
    logic [ADDRESS_BITS-1:0] row;
  } skip_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [WIDTH_BITS-1:0]   column;
    logic [ADDRESS_BITS-1:0] row;
  } skip_rsp_t;

  function automatic logic [COLOR_BITS-1:0] expand_color(input logic [15:0] c);
    expand_color = {8'hFF, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/srle_skip_unit.sv
// ----------------------------------------------------------------------------
// Sprite RLE skip unit
// Applies a transparent skip to the column and row address with one shared
// add/subtract unit: restoring division by the image width, column wrap fix,
// then shift-and-add multiplication of the row count by the atlas pitch.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_skip_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire srle_pkg::skip_req_t                 req,
  input  wire logic [srle_pkg::WIDTH_BITS-1:0]     width,
  input  wire logic [srle_pkg::ATLAS_BITS-1:0]     row_pitch,
  output srle_pkg::skip_rsp_t                      rsp
);

  srle_pkg::skip_state_t state_r, state_nxt;

  logic [srle_pkg::STEP_BITS-1:0]    cnt_r, cnt_nxt;
  logic [srle_pkg::BYTE_BITS-1:0]    dvd_r, dvd_nxt;
  logic [srle_pkg::BYTE_BITS-1:0]    quo_r, quo_nxt;
  logic [srle_pkg::WIDTH_BITS-1:0]   rem_r, rem_nxt;
  logic [srle_pkg::WIDTH_BITS-1:0]   col_r, col_nxt;
  logic [srle_pkg::WIDTH_BITS:0]     colsum_r, colsum_nxt;
  logic [srle_pkg::ROWS_BITS-1:0]    rows_r, rows_nxt;
  logic [srle_pkg::ADDRESS_BITS-1:0] md_r, md_nxt;
  logic [srle_pkg::ADDRESS_BITS-1:0] row_r, row_nxt;

  logic [srle_pkg::ALU_BITS-1:0] alu_a;
  logic [srle_pkg::ALU_BITS-1:0] alu_b;
  logic                          alu_sub;
  logic [srle_pkg::ALU_BITS-1:0] alu_y;
  logic                          alu_neg;
  logic [srle_pkg::WIDTH_BITS:0] trial;
  logic                          done;

  assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg = alu_y[srle_pkg::ALU_BITS-1];
  assign trial   = {rem_r, dvd_r[srle_pkg::BYTE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srle_pkg::SK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    dvd_r    <= dvd_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    col_r    <= col_nxt;
    colsum_r <= colsum_nxt;
    rows_r   <= rows_nxt;
    md_r     <= md_nxt;
    row_r    <= row_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    col_nxt    = col_r;
    colsum_nxt = colsum_r;
    rows_nxt   = rows_r;
    md_nxt     = md_r;
    row_nxt    = row_r;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    done       = 1'b0;
    case (state_r)
      srle_pkg::SK_IDLE: begin
        if (start) begin
          dvd_nxt   = req.skip;
          quo_nxt   = '0;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          col_nxt   = req.column;
          row_nxt   = req.row;
          state_nxt = srle_pkg::SK_DIV;
        end
      end
      srle_pkg::SK_DIV: begin
        alu_a   = srle_pkg::ALU_BITS'(trial);
        alu_b   = srle_pkg::ALU_BITS'(width);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          rem_nxt = alu_y[srle_pkg::WIDTH_BITS-1:0];
        end else begin
          rem_nxt = trial[srle_pkg::WIDTH_BITS-1:0];
        end
        quo_nxt = {quo_r[srle_pkg::BYTE_BITS-2:0], !alu_neg};
        dvd_nxt = {dvd_r[srle_pkg::BYTE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + srle_pkg::STEP_BITS'(1);
        if (cnt_r == srle_pkg::STEP_BITS'(srle_pkg::BYTE_BITS - 1)) begin
          state_nxt = srle_pkg::SK_FIX_ADD;
        end
      end
      srle_pkg::SK_FIX_ADD: begin
        alu_a      = srle_pkg::ALU_BITS'(col_r);
        alu_b      = srle_pkg::ALU_BITS'(rem_r);
        colsum_nxt = alu_y[srle_pkg::WIDTH_BITS:0];
        state_nxt  = srle_pkg::SK_FIX_SUB;
      end
      srle_pkg::SK_FIX_SUB: begin
        alu_a   = srle_pkg::ALU_BITS'(colsum_r);
        alu_b   = srle_pkg::ALU_BITS'(width);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          col_nxt  = alu_y[srle_pkg::WIDTH_BITS-1:0];
          rows_nxt = {1'b0, quo_r} + srle_pkg::ROWS_BITS'(1);
        end else begin
          col_nxt  = colsum_r[srle_pkg::WIDTH_BITS-1:0];
          rows_nxt = {1'b0, quo_r};
        end
        md_nxt    = srle_pkg::ADDRESS_BITS'(row_pitch);
        state_nxt = srle_pkg::SK_MUL;
      end
      srle_pkg::SK_MUL: begin
        if (rows_r == '0) begin
          done      = 1'b1;
          state_nxt = srle_pkg::SK_IDLE;
        end else begin
          alu_a = srle_pkg::ALU_BITS'(row_r);
          alu_b = srle_pkg::ALU_BITS'(md_r);
          if (rows_r[0]) begin
            row_nxt = alu_y[srle_pkg::ADDRESS_BITS-1:0];
          end
          rows_nxt = {1'b0, rows_r[srle_pkg::ROWS_BITS-1:1]};
          md_nxt   = {md_r[srle_pkg::ADDRESS_BITS-2:0], 1'b0};
        end
      end
      default: begin
        state_nxt = srle_pkg::SK_IDLE;
      end
    endcase
  end

  assign rsp = {(state_r != srle_pkg::SK_IDLE), done, col_r, row_r};

  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == srle_pkg::SK_IDLE) |=> state_r == srle_pkg::SK_DIV)
    else $error("skip unit did not begin division after start");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srle_pkg::SK_DIV &&
     cnt_r != srle_pkg::STEP_BITS'(srle_pkg::BYTE_BITS - 1))
    |=> state_r == srle_pkg::SK_DIV)
    else $error("division left early");

  a_rows_from_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srle_pkg::SK_FIX_SUB |=>
    (rows_r == {1'b0, $past(quo_r)}) ||
    (rows_r == {1'b0, $past(quo_r)} + srle_pkg::ROWS_BITS'(1)))
    else $error("row count does not follow the quotient");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> state_r == srle_pkg::SK_IDLE)
    else $error("skip unit stayed busy after done");

endmodule

`default_nettype wire

// File: rtl/sprite_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// Sprite RLE pixel decoder core
// A pixel reaches the output register in the cycle after its high byte moves.
// Control, pixel and ignored bytes are taken one per cycle while the skip unit
// is idle and the output is free. A skip byte holds in_ready low in the skip
// unit: eight division steps, two column steps, then one per bit of the row count.
// Reset (rst_n, synchronous) restores the register defaults and the decoder
// state; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rle_pixel_decoder_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire srle_pkg::in_t                        in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output srle_pkg::out_t                            out_data,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [srle_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [srle_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [srle_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                      pready
);

  logic [srle_pkg::WIDTH_BITS-1:0]   image_width_r;
  logic [srle_pkg::ATLAS_BITS-1:0]   row_pitch_r;
  logic [srle_pkg::ADDRESS_BITS-1:0] base_address_r;
  logic [srle_pkg::LENGTH_BITS-1:0]  stream_length_r;

  srle_pkg::phase_t                  phase_r, phase_nxt;
  logic [srle_pkg::WIDTH_BITS-1:0]   column_r, column_nxt;
  logic [srle_pkg::ADDRESS_BITS-1:0] row_r, row_nxt;
  logic [srle_pkg::BYTE_BITS-1:0]    run_left_r, run_left_nxt;
  logic [srle_pkg::BYTE_BITS-1:0]    low_hold_r, low_hold_nxt;
  logic [srle_pkg::LENGTH_BITS-1:0]  bytes_left_r, bytes_left_nxt;
  logic                              out_valid_r, out_valid_nxt;
  srle_pkg::out_t                    out_r, out_nxt;

  srle_pkg::phase_t                  eff_phase;
  logic [srle_pkg::WIDTH_BITS-1:0]   eff_column;
  logic [srle_pkg::ADDRESS_BITS-1:0] eff_row;
  logic [srle_pkg::BYTE_BITS-1:0]    eff_run;
  logic [srle_pkg::BYTE_BITS-1:0]    eff_low;
  logic [srle_pkg::LENGTH_BITS-1:0]  eff_left;

  logic [srle_pkg::WIDTH_BITS-1:0]   width;
  logic [srle_pkg::WIDTH_BITS:0]     col_inc;
  logic [srle_pkg::WIDTH_BITS:0]     col_wrap;
  logic [srle_pkg::BYTE_BITS-1:0]    run_dec;
  logic                              accept;
  logic                              cfg_write;
  logic                              skip_start;
  srle_pkg::skip_req_t               skip_req;
  srle_pkg::skip_rsp_t               skip_rsp;

  assign width     = (image_width_r == '0) ? srle_pkg::WIDTH_BITS'(1) : image_width_r;
  assign in_ready  = !skip_rsp.busy && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= srle_pkg::WIDTH_BITS'(1);
      row_pitch_r     <= srle_pkg::ATLAS_BITS'(1);
      base_address_r  <= '0;
      stream_length_r <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        srle_pkg::REG_IMAGE_WIDTH:   image_width_r   <= pwdata[srle_pkg::WIDTH_BITS-1:0];
        srle_pkg::REG_ROW_PITCH:     row_pitch_r     <= pwdata[srle_pkg::ATLAS_BITS-1:0];
        srle_pkg::REG_BASE_ADDRESS:  base_address_r  <= pwdata[srle_pkg::ADDRESS_BITS-1:0];
        srle_pkg::REG_STREAM_LENGTH: stream_length_r <= pwdata[srle_pkg::LENGTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      srle_pkg::REG_IMAGE_WIDTH:   prdata = srle_pkg::CFG_DATA_BITS'(image_width_r);
      srle_pkg::REG_ROW_PITCH:     prdata = srle_pkg::CFG_DATA_BITS'(row_pitch_r);
      srle_pkg::REG_BASE_ADDRESS:  prdata = srle_pkg::CFG_DATA_BITS'(base_address_r);
      srle_pkg::REG_STREAM_LENGTH: prdata = srle_pkg::CFG_DATA_BITS'(stream_length_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= srle_pkg::PH_CONTROL;
      column_r     <= '0;
      row_r        <= '0;
      run_left_r   <= '0;
      low_hold_r   <= '0;
      bytes_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      run_left_r   <= run_left_nxt;
      low_hold_r   <= low_hold_nxt;
      bytes_left_r <= bytes_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    if (in_data.start_image) begin
      eff_phase  = srle_pkg::PH_CONTROL;
      eff_column = '0;
      eff_row    = base_address_r;
      eff_run    = '0;
      eff_low    = '0;
      eff_left   = stream_length_r;
    end else begin
      eff_phase  = phase_r;
      eff_column = column_r;
      eff_row    = row_r;
      eff_run    = run_left_r;
      eff_low    = low_hold_r;
      eff_left   = bytes_left_r;
    end
  end

  assign col_inc  = {1'b0, eff_column} + (srle_pkg::WIDTH_BITS + 1)'(1);
  assign col_wrap = col_inc - {1'b0, width};
  assign run_dec  = eff_run - srle_pkg::BYTE_BITS'(1);

  assign skip_req.skip   = in_data.data_byte;
  assign skip_req.column = eff_column;
  assign skip_req.row    = eff_row;

  always_comb begin
    phase_nxt      = phase_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    run_left_nxt   = run_left_r;
    low_hold_nxt   = low_hold_r;
    bytes_left_nxt = bytes_left_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    skip_start     = 1'b0;
    if (skip_rsp.done) begin
      column_nxt = skip_rsp.column;
      row_nxt    = skip_rsp.row;
    end
    if (accept) begin
      phase_nxt      = eff_phase;
      column_nxt     = eff_column;
      row_nxt        = eff_row;
      run_left_nxt   = eff_run;
      low_hold_nxt   = eff_low;
      bytes_left_nxt = eff_left;
      if (!(eff_phase == srle_pkg::PH_CONTROL && eff_left == '0)) begin
        if (eff_left != '0) begin
          bytes_left_nxt = eff_left - srle_pkg::LENGTH_BITS'(1);
        end
        case (eff_phase)
          srle_pkg::PH_CONTROL: begin
            if (in_data.data_byte == srle_pkg::SKIP_CONTROL) begin
              phase_nxt = srle_pkg::PH_SKIP;
            end else if (in_data.data_byte != '0) begin
              run_left_nxt = in_data.data_byte;
              phase_nxt    = srle_pkg::PH_LOW;
            end
          end
          srle_pkg::PH_SKIP: begin
            skip_start = 1'b1;
            phase_nxt  = srle_pkg::PH_CONTROL;
          end
          srle_pkg::PH_LOW: begin
            low_hold_nxt = in_data.data_byte;
            phase_nxt    = srle_pkg::PH_HIGH;
          end
          srle_pkg::PH_HIGH: begin
            out_nxt.pixel_address = eff_row + srle_pkg::ADDRESS_BITS'(eff_column);
            out_nxt.pixel_color   = srle_pkg::expand_color({in_data.data_byte, eff_low});
            out_valid_nxt         = 1'b1;
            if (!col_wrap[srle_pkg::WIDTH_BITS]) begin
              column_nxt = col_wrap[srle_pkg::WIDTH_BITS-1:0];
              row_nxt    = eff_row + srle_pkg::ADDRESS_BITS'(row_pitch_r);
            end else begin
              column_nxt = col_inc[srle_pkg::WIDTH_BITS-1:0];
            end
            run_left_nxt = run_dec;
            phase_nxt    = (run_dec == '0) ? srle_pkg::PH_CONTROL : srle_pkg::PH_LOW;
          end
          default: begin
            phase_nxt = srle_pkg::PH_CONTROL;
          end
        endcase
      end
    end
  end

  srle_skip_unit u_skip (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (skip_start),
    .req       (skip_req),
    .width     (width),
    .row_pitch (row_pitch_r),
    .rsp       (skip_rsp)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    skip_rsp.busy |-> !in_ready)
    else $error("input taken while the skip unit is busy");

  a_skip_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    skip_start |=> skip_rsp.busy)
    else $error("skip byte did not start the skip unit");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result changed while it waited for transfer");

endmodule

`default_nettype wire

// File: test/srle_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE decoder pixel checker
// Follows register writes and stream byte transfers into the decoder and
// predicts the pixel writes they cause. Each result transfer is compared,
// field by field, with the oldest predicted write.
// ----------------------------------------------------------------------------
module srle_pixel_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire srle_pkg::in_t               in_data,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire srle_pkg::out_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srle_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [srle_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  wire logic                        pready,
  output int                               failures,
  output int                               pending,
  output int                               pixels_checked
);
  import srle_pkg::*;

  logic [WIDTH_BITS-1:0]   image_width;
  logic [ATLAS_BITS-1:0]   row_pitch;
  logic [ADDRESS_BITS-1:0] base_address;
  logic [LENGTH_BITS-1:0]  stream_length;

  phase_t                  phase;
  logic [WIDTH_BITS-1:0]   column;
  logic [ADDRESS_BITS-1:0] row_address;
  logic [BYTE_BITS-1:0]    run_left;
  logic [BYTE_BITS-1:0]    low_hold;
  logic [LENGTH_BITS:0]    bytes_left;

  out_t pixel_writes[$];
  int   fail_count = 0;
  int   checked_count = 0;

  function automatic logic [COLOR_BITS-1:0] argb_from_rgb555(input logic [15:0] c);
    logic [31:0] x;
    x = {16'd0, c};
    return 32'hFF000000 |
           ((x & 32'h7c00) << 9) | ((x & 32'h7000) << 4) |
           ((x & 32'h03e0) << 6) | ((x & 32'h0380) << 1) |
           ((x & 32'h001f) << 3) | ((x & 32'h001c) >> 2);
  endfunction

  task automatic advance_rows(input logic [ROWS_BITS-1:0] rows);
    logic [ADDRESS_BITS-1:0] step;
    step = rows * row_pitch;
    row_address = row_address + step;
  endtask

  task automatic decode_byte(input in_t item);
    logic [WIDTH_BITS:0]    w;
    logic [WIDTH_BITS:0]    col;
    logic [ROWS_BITS-1:0]   rows;
    logic [BYTE_BITS-1:0]   b;
    out_t                   px;
    b = item.data_byte;
    if (item.start_image) begin
      phase = PH_CONTROL;
      column = '0;
      row_address = base_address;
      run_left = '0;
      low_hold = '0;
      bytes_left = stream_length;
    end
    if (phase == PH_CONTROL && bytes_left == 0) return;
    if (bytes_left != 0) bytes_left = bytes_left - 1;
    w = (image_width == 0) ? 1 : image_width;
    case (phase)
      PH_CONTROL: begin
        if (b == SKIP_CONTROL) begin
          phase = PH_SKIP;
        end else if (b != 0) begin
          run_left = b;
          phase = PH_LOW;
        end
      end
      PH_SKIP: begin
        rows = b / w;
        col = column + b % w;
        if (col >= w) begin
          rows = rows + 1;
          col = col - w;
        end
        column = col[WIDTH_BITS-1:0];
        advance_rows(rows);
        phase = PH_CONTROL;
      end
      PH_LOW: begin
        low_hold = b;
        phase = PH_HIGH;
      end
      default: begin
        px.pixel_address = row_address + column;
        px.pixel_color = argb_from_rgb555({b, low_hold});
        pixel_writes.insert(pixel_writes.size(), px);
        col = column + 1;
        if (col >= w) begin
          advance_rows(1);
          col = col - w;
        end
        column = col[WIDTH_BITS-1:0];
        run_left = run_left - 1;
        phase = (run_left == 0) ? PH_CONTROL : PH_LOW;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      image_width = 1;
      row_pitch = 1;
      base_address = '0;
      stream_length = '0;
      phase = PH_CONTROL;
      column = '0;
      row_address = '0;
      run_left = '0;
      low_hold = '0;
      bytes_left = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_BITS-1:2])
          REG_IMAGE_WIDTH:   image_width = pwdata[WIDTH_BITS-1:0];
          REG_ROW_PITCH:     row_pitch = pwdata[ATLAS_BITS-1:0];
          REG_BASE_ADDRESS:  base_address = pwdata[ADDRESS_BITS-1:0];
          REG_STREAM_LENGTH: stream_length = pwdata[LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pixel_writes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel write: expected none, got address %h color %h",
                   $time, out_data.pixel_address, out_data.pixel_color);
        end else begin
          out_t want;
          want = pixel_writes.pop_front();
          checked_count++;
          if (out_data.pixel_address !== want.pixel_address ||
              out_data.pixel_color !== want.pixel_color) begin
            fail_count++;
            if (out_data.pixel_address !== want.pixel_address)
              $display("%0t: pixel_address mismatch: expected %h, got %h",
                       $time, want.pixel_address, out_data.pixel_address);
            if (out_data.pixel_color !== want.pixel_color)
              $display("%0t: pixel_color mismatch: expected %h, got %h",
                       $time, want.pixel_color, out_data.pixel_color);
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_data);
    end
    failures <= fail_count;
    pending <= pixel_writes.size();
    pixels_checked <= checked_count;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE decoder testbench
// Drives directed and random compressed sprite streams into the decoder under
// changing register settings and idle patterns on both channels, and reports
// the verdict from the pixel checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  import srle_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_BYTES   = 200;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  in_t                      in_data = '0;
  logic                     in_ready;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int failures;
  int pending;
  int pixels_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int streams_run = 0;
  int cycle_count = 0;

  logic [BYTE_BITS-1:0] stream_bytes[$];

  sprite_rle_pixel_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  srle_pixel_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .failures       (failures),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_byte(input logic [BYTE_BITS-1:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endtask

  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic st);
    in_t item;
    item.data_byte = b;
    item.start_image = st;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_sprite(input bit with_long_run);
    int          items;
    int          kind;
    int          run;
    int          i;
    int          j;
    int          k;
    int          restart_at;
    int          split_at;
    int          noise;
    int unsigned size;
    int unsigned len_sel;
    int unsigned length;
    logic [WIDTH_BITS-1:0] img_w;
    settle();
    stream_bytes.delete();
    items = $urandom_range(1, 8);
    for (i = 0; i < items; i++) begin
      kind = (with_long_run && i == 0) ? 99 : $urandom_range(99);
      if (kind < 20) begin
        queue_byte(SKIP_CONTROL);
        case ($urandom_range(3))
          0:       queue_byte(8'hFF);
          1:       queue_byte(8'h00);
          default: queue_byte(8'($urandom_range(255)));
        endcase
      end else if (kind < 26) begin
        queue_byte(8'h00);
      end else begin
        if (with_long_run && i == 0) run = $urandom_range(128, 150);
        else if ($urandom_range(99) < 15) run = $urandom_range(7, 40);
        else run = $urandom_range(1, 6);
        queue_byte(8'(run));
        for (j = 0; j < 2 * run; j++) queue_byte(8'($urandom));
      end
    end

    case ($urandom_range(9))
      0:          img_w = 12'd0;
      1:          img_w = 12'd1;
      2:          img_w = 12'd4095;
      3, 4, 5, 6: img_w = 12'($urandom_range(2, 16));
      default:    img_w = 12'($urandom_range(1, 4095));
    endcase
    cfg_write(REG_IMAGE_WIDTH, 32'(img_w));
    case ($urandom_range(5))
      0:       cfg_write(REG_ROW_PITCH, 32'd1);
      1:       cfg_write(REG_ROW_PITCH, 32'd8192);
      default: cfg_write(REG_ROW_PITCH, 32'($urandom_range(1, 8192)));
    endcase
    case ($urandom_range(5))
      0:       cfg_write(REG_BASE_ADDRESS, 32'd0);
      1:       cfg_write(REG_BASE_ADDRESS, 32'h03FFFFFF);
      2:       cfg_write(REG_BASE_ADDRESS, 32'h03FFFFFF - $urandom_range(64));
      default: cfg_write(REG_BASE_ADDRESS, 32'($urandom_range(0, 32'h03FFFFFF)));
    endcase

    size = stream_bytes.size();
    restart_at = -1;
    len_sel = $urandom_range(99);
    if (len_sel < 70) begin
      length = size;
    end else if (len_sel < 80) begin
      length = size - $urandom_range(1, size);
    end else if (len_sel < 90) begin
      length = ($urandom_range(3) == 0) ? 32'h00FFFFFF : size + $urandom_range(1, 5);
    end else begin
      length = size;
      restart_at = $urandom_range(1, size - 1);
    end
    cfg_write(REG_STREAM_LENGTH, 32'(length));

    split_at = ($urandom_range(99) < 15) ? $urandom_range(1, size - 1) : -1;
    for (k = 0; k < size; k++) begin
      if (k == split_at) begin
        settle();
        cfg_write(REG_IMAGE_WIDTH, 32'($urandom_range(0, 8)));
        if ($urandom_range(1) == 1) cfg_write(REG_ROW_PITCH, 32'($urandom_range(1, 8192)));
      end
      send_byte(stream_bytes[k], (k == 0) || (k == restart_at));
    end
    noise = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    for (k = 0; k < noise; k++) send_byte(8'($urandom), 1'b0);
    streams_run++;
  endtask

  initial begin
    int  mode;
    int  phase_goal;
    bit  first;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 74;

    // With the reset length of zero a restart leaves nothing to decode.
    send_byte(8'h07, 1'b1);
    settle();
    cfg_write(REG_IMAGE_WIDTH, 32'd4);
    cfg_write(REG_ROW_PITCH, 32'd8192);
    cfg_write(REG_BASE_ADDRESS, 32'h03FFFFFD);
    cfg_write(REG_STREAM_LENGTH, 32'd11);
    send_byte(8'h02, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hA5, 1'b0); send_byte(8'h5A, 1'b0);
    send_byte(8'h07, 1'b0);
    settle();
    // Zero width, and a run that goes on past the end of the stream length.
    cfg_write(REG_IMAGE_WIDTH, 32'd0);
    cfg_write(REG_STREAM_LENGTH, 32'd3);
    send_byte(8'h05, 1'b1); send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0); send_byte(8'h78, 1'b0); send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b0); send_byte(8'hDE, 1'b0); send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h03, 1'b0);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_goal = bytes_sent + PHASE_BYTES;
      first = 1'b1;
      while (bytes_sent < phase_goal) begin
        random_sprite(mode == 2 && first);
        first = 1'b0;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d stream bytes in %0d sprite streams, %0d pixel writes checked.",
             bytes_sent, streams_run, pixels_checked);
    $display("Streams mixed skips, zero runs, truncation, restarts and width changes.");
    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
